// File: hw/rtl/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the server selection policy block.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int OP_W        = 3;
    localparam int MODE_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int WGT_W       = 16;
    localparam int CONN_W      = 16;
    localparam int RSP_W       = 16;
    localparam int RND_W       = 20;
    localparam int CTR_W       = 32;
    localparam int AVG_W       = 20;
    localparam int SUM_W       = 24;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int DIV_CNT_W   = 5;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 120;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SETW   = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd4;
    localparam logic [OP_W-1:0] OP_SETC   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_RR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LRT = 2'd3;

    // Reciprocal of ten, scaled by two to the DIV10_SHIFT.
    localparam logic [SUM_W-1:0] DIV10_MUL   = 24'd13421773;
    localparam int               DIV10_SHIFT = 27;
    localparam logic [AVG_W-1:0] AVG_MAX     = 20'hFFFFF;

    typedef struct packed {
        logic [WGT_W-1:0]  weight;
        logic [CONN_W-1:0] conn;
        logic [CTR_W-1:0]  total;
        logic [CTR_W-1:0]  failed;
        logic [AVG_W-1:0]  avg;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd_slot;
        logic exec;
        logic mul;
        logic wr_report;
        logic scan_step;
        logic scan_drain;
        logic div_step;
        logic rr_step;
        logic rr_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        logic              cnt_zero;
        logic              scan_last;
        logic              div_last;
        logic              out_free;
    } t_sts;

endpackage

// File: hw/rtl/ssp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  ssp_pkg::t_sts i_sts,
    output ssp_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_WR     = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_MOD    = 4'd7;
    localparam logic [3:0] S_RRSCAN = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_slot = 1'b1;
                if (i_sts.op == ssp_pkg::OP_SELECT) begin
                    if (i_sts.cnt_zero) begin
                        n_state = S_OUT;
                    end else if (i_sts.mode == ssp_pkg::MODE_RR) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_sts.op == ssp_pkg::OP_REPORT) ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.wr_report = 1'b1;
                n_state         = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.scan_drain = 1'b1;
                n_state          = S_OUT;
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RRSCAN;
                end
            end
            S_RRSCAN: begin
                o_cmd.rr_step = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.rr_inc = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ssp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_datapath
// Slot table, statistics arithmetic, selection scans and result register.
// ----------------------------------------------------------------------------
module ssp_datapath #(
    parameter int MAX_SERVERS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ssp_pkg::MODE_W-1:0]          i_cfg_wr_data,
    input  logic [ssp_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic [ssp_pkg::OP_W-1:0]            i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ssp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tuser,
    input  ssp_pkg::t_cmd                       i_cmd,
    output ssp_pkg::t_sts                       o_sts
);

    localparam int IW = $clog2(MAX_SERVERS);
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int SW = (IW > ssp_pkg::SLOT_W) ? IW : ssp_pkg::SLOT_W;

    ssp_pkg::t_entry mem [MAX_SERVERS];
    ssp_pkg::t_entry r_rd;
    ssp_pkg::t_entry w_data;
    logic            w_en;
    logic [IW-1:0]   rd_addr;

    logic [ssp_pkg::OP_W-1:0]   r_op;
    logic [ssp_pkg::SLOT_W-1:0] r_slot;
    logic [ssp_pkg::WGT_W-1:0]  r_wv;
    logic                       r_ok;
    logic [ssp_pkg::RSP_W-1:0]  r_rms;
    logic [ssp_pkg::CONN_W-1:0] r_cv;
    logic [ssp_pkg::RND_W-1:0]  r_rnd;

    logic [ssp_pkg::MODE_W-1:0] r_mode;
    logic [MAX_SERVERS-1:0]     r_valid;
    logic [CW-1:0]              r_cnt;
    logic [ssp_pkg::CTR_W-1:0]  r_rr;
    logic                       r_sv;

    logic [IW-1:0]              r_idx;
    logic [IW-1:0]              r_pidx;
    logic                       r_pend;
    logic                       r_have;
    logic                       r_hit;
    logic [IW-1:0]              r_best;
    logic [IW-1:0]              r_first;
    logic [ssp_pkg::AVG_W-1:0]  r_bestv;
    logic [ssp_pkg::CTR_W-1:0]  r_run;
    logic [CW-1:0]              r_seen;
    logic [CW-1:0]              r_rem;
    logic [ssp_pkg::DIV_CNT_W-1:0] r_dcnt;

    logic [IW-1:0]              n_best;
    logic [IW-1:0]              n_first;
    logic [ssp_pkg::AVG_W-1:0]  n_bestv;
    logic [ssp_pkg::CTR_W-1:0]  n_run;
    logic [CW-1:0]              n_seen;
    logic                       n_have;
    logic                       n_hit;

    logic [ssp_pkg::SUM_W-1:0]  r_sum;
    logic [ssp_pkg::PROD_W-1:0] r_prod;

    logic                         r_ovalid;
    logic [ssp_pkg::OUT_TDATA_W-1:0] r_otdata;
    logic [ssp_pkg::OUT_TDATA_W-1:0] n_otdata;
    logic                         r_otuser;

    logic [SW-1:0]              slot_ext;
    logic [IW-1:0]              s_idx;
    logic                       slot_in_range;
    logic                       eval_en;
    logic [ssp_pkg::CTR_W-1:0]  run_sum;
    logic [ssp_pkg::AVG_W-1:0]  key;
    logic [IW-1:0]              chosen_idx;
    logic [SW-1:0]              chosen_ext;
    logic [CW:0]                rem2;
    logic [CW:0]                rem_sub;
    logic [ssp_pkg::AVG_W:0]    avg_q;
    logic [ssp_pkg::AVG_W-1:0]  avg_new;
    logic                       is_sel;
    logic                       show_stats;

    assign slot_ext = SW'(r_slot);
    assign s_idx    = slot_ext[IW-1:0];
    assign slot_in_range = (32'(r_slot) < MAX_SERVERS);
    assign rd_addr  = i_cmd.scan_step ? r_idx : s_idx;
    assign eval_en  = (i_cmd.scan_step || i_cmd.scan_drain) && r_pend;
    assign run_sum  = r_run + ssp_pkg::CTR_W'(r_rd.weight);
    assign key      = (r_mode == ssp_pkg::MODE_LC) ? ssp_pkg::AVG_W'(r_rd.conn) : r_rd.avg;
    assign rem2     = {r_rem, r_rr[5'd31 - r_dcnt]};
    assign rem_sub  = rem2 - {1'b0, r_cnt};
    assign avg_q    = r_prod[ssp_pkg::DIV10_SHIFT +: (ssp_pkg::AVG_W + 1)];
    assign avg_new  = avg_q[ssp_pkg::AVG_W] ? ssp_pkg::AVG_MAX : avg_q[ssp_pkg::AVG_W-1:0];
    assign chosen_idx = (r_mode == ssp_pkg::MODE_WR && !r_hit) ? r_first : r_best;
    assign chosen_ext = SW'(chosen_idx);
    assign is_sel     = (r_op == ssp_pkg::OP_SELECT);
    assign show_stats = (r_op == ssp_pkg::OP_READ) && r_sv;

    always_comb begin
        w_en   = 1'b0;
        w_data = r_rd;
        if (i_cmd.exec) begin
            case (r_op)
                ssp_pkg::OP_ADD: begin
                    w_en          = slot_in_range;
                    w_data        = '0;
                    w_data.weight = r_wv;
                end
                ssp_pkg::OP_SETW: begin
                    w_en          = r_sv;
                    w_data.weight = r_wv;
                end
                ssp_pkg::OP_SETC: begin
                    w_en        = r_sv;
                    w_data.conn = r_cv;
                end
                default: begin
                    w_en = 1'b0;
                end
            endcase
        end else if (i_cmd.wr_report) begin
            w_en          = r_sv;
            w_data.total  = r_rd.total + 1'b1;
            w_data.failed = r_rd.failed + ssp_pkg::CTR_W'(!r_ok);
            w_data.avg    = avg_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[s_idx] <= w_data;
        end
        if (i_cmd.rd_slot || i_cmd.scan_step) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        n_best  = r_best;
        n_first = r_first;
        n_bestv = r_bestv;
        n_run   = r_run;
        n_seen  = r_seen;
        n_have  = r_have;
        n_hit   = r_hit;
        if (eval_en && r_valid[r_pidx]) begin
            if (r_mode == ssp_pkg::MODE_WR) begin
                if (!r_have) begin
                    n_have  = 1'b1;
                    n_first = r_pidx;
                end
                if (!r_hit) begin
                    n_run = run_sum;
                    if (ssp_pkg::CTR_W'(r_rnd) < run_sum) begin
                        n_hit  = 1'b1;
                        n_best = r_pidx;
                    end
                end
            end else if (!r_have || key < r_bestv) begin
                n_have  = 1'b1;
                n_best  = r_pidx;
                n_bestv = key;
            end
        end
        if (i_cmd.rr_step && r_valid[r_idx] && !r_hit) begin
            if (r_seen == r_rem) begin
                n_hit  = 1'b1;
                n_have = 1'b1;
                n_best = r_idx;
            end else begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_s_axis_tuser;
            r_slot <= i_s_axis_tdata[3:0];
            r_wv   <= i_s_axis_tdata[19:4];
            r_ok   <= i_s_axis_tdata[20];
            r_rms  <= i_s_axis_tdata[36:21];
            r_cv   <= i_s_axis_tdata[52:37];
            r_rnd  <= i_s_axis_tdata[72:53];
        end
        if (i_cmd.rd_slot) begin
            r_sv    <= slot_in_range && r_valid[s_idx];
            r_idx   <= '0;
            r_pidx  <= '0;
            r_pend  <= 1'b0;
            r_have  <= 1'b0;
            r_hit   <= 1'b0;
            r_best  <= '0;
            r_first <= '0;
            r_bestv <= '0;
            r_run   <= '0;
            r_seen  <= '0;
            r_rem   <= '0;
            r_dcnt  <= '0;
        end else begin
            r_best  <= n_best;
            r_first <= n_first;
            r_bestv <= n_bestv;
            r_run   <= n_run;
            r_seen  <= n_seen;
            r_have  <= n_have;
            r_hit   <= n_hit;
            if (i_cmd.scan_step) begin
                r_pidx <= r_idx;
                r_pend <= 1'b1;
                r_idx  <= r_idx + 1'b1;
            end else if (i_cmd.scan_drain) begin
                r_pend <= 1'b0;
            end else if (i_cmd.rr_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.div_step) begin
                r_rem  <= rem_sub[CW] ? rem2[CW-1:0] : rem_sub[CW-1:0];
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
        if (i_cmd.exec) begin
            r_sum <= {4'b0, r_rms, 4'b0}
                   + ssp_pkg::SUM_W'(r_rd.avg) * ssp_pkg::SUM_W'(9);
        end
        if (i_cmd.mul) begin
            r_prod <= {{ssp_pkg::SUM_W{1'b0}}, r_sum}
                    * {{ssp_pkg::SUM_W{1'b0}}, ssp_pkg::DIV10_MUL};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ssp_pkg::MODE_RR;
            r_valid <= '0;
            r_cnt   <= '0;
            r_rr    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.exec && slot_in_range) begin
                if (r_op == ssp_pkg::OP_ADD) begin
                    r_valid[s_idx] <= 1'b1;
                    if (!r_valid[s_idx]) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end else if (r_op == ssp_pkg::OP_REMOVE) begin
                    r_valid[s_idx] <= 1'b0;
                    if (r_valid[s_idx]) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
            if (i_cmd.rr_inc) begin
                r_rr <= r_rr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        n_otdata      = '0;
        n_otdata[3:0] = is_sel ? chosen_ext[3:0] : r_slot;
        if (show_stats) begin
            n_otdata[19:4]    = r_rd.weight;
            n_otdata[35:20]   = r_rd.conn;
            n_otdata[67:36]   = r_rd.total;
            n_otdata[99:68]   = r_rd.failed;
            n_otdata[119:100] = r_rd.avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_otuser <= is_sel ? r_have : r_sv;
            r_otdata <= n_otdata;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_otuser;

    assign o_sts.op        = r_op;
    assign o_sts.mode      = r_mode;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.scan_last = (r_idx == IW'(MAX_SERVERS - 1));
    assign o_sts.div_last  = (r_dcnt == '1);
    assign o_sts.out_free  = !r_ovalid || i_m_axis_tready;

`ifndef SYNTHESIS
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'($countones(r_valid)))
        else $error("valid count differs from valid bits");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_cnt))
        else $error("remainder not below valid count");
    a_rr_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rr_inc |=> r_hit)
        else $error("round robin scan found no slot");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_m_axis_tready))
        else $error("result overwritten before taken");
`endif

endmodule

// File: hw/rtl/server_selection_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// server_selection_policy
// Server slot table with round robin, least connections, weighted and
// least response time selection.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the operation and
// tdata the slot, weight, success flag, response time, connection count
// and random value. Each request gives one result on m_axis: tuser is the
// found flag, tdata the chosen slot and the slot statistics.
// The user writes the policy register through i_cfg_wr_en and i_cfg_wr_data
// only while no request is in flight; the block does not enforce this.
// One request is handled at a time. Add, remove, set and read pass the
// slot read and execute states to the result register, a report also the
// multiply and write back states. A least connections, least response time
// or weighted select scans the table through its one read port; a round
// robin select first runs a bit-serial modulo, then scans the valid bits.
// Reset clears all slot valid bits, the round robin counter and the policy.
// When the receiver stalls, the result holds; the next request is accepted
// and worked on, and waits for the result register to empty.
// ----------------------------------------------------------------------------
module server_selection_policy #(
    parameter int MAX_SERVERS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ssp_pkg::MODE_W-1:0]        i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // slot, weight_value, success, response_ms, conn_value, rand_value
    input  logic [ssp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // op
    input  logic [ssp_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // chosen_slot, stat_weight, stat_connections, stat_total, stat_failed,
    // stat_resp_avg
    output logic [ssp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // found
    output logic                              o_m_axis_tuser
);

    ssp_pkg::t_cmd cmd;
    ssp_pkg::t_sts sts;

    ssp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    ssp_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

// File: tb/tb_server_selection_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_server_selection_policy
// Drives slot table requests into the server selection policy block under
// all four policies and compares every result with a local prediction of
// the slot table, with random idling on both stream sides.
// ----------------------------------------------------------------------------

class ssp_scoreboard;
    bit            valid_q[16];
    bit [15:0]     weight_q[16];
    bit [15:0]     conn_q[16];
    bit [31:0]     total_q[16];
    bit [31:0]     failed_q[16];
    bit [19:0]     avg_q[16];
    bit [31:0]     rr_count;
    bit [1:0]      mode;
    bit [120:0]    pending[$];
    int            errors;

    function void clear();
        for (int i = 0; i < 16; i++) begin
            valid_q[i] = 0; weight_q[i] = 0; conn_q[i] = 0;
            total_q[i] = 0; failed_q[i] = 0; avg_q[i] = 0;
        end
        rr_count = 0;
        mode = 0;
        errors = 0;
    endfunction

    function int pick(bit [19:0] rnd);
        int cnt;
        int first;
        int best;
        int seen;
        bit [31:0] target;
        bit [31:0] run;
        cnt = 0; first = -1; best = -1; seen = 0; run = 0;
        for (int i = 0; i < 16; i++) begin
            if (valid_q[i]) begin
                if (first < 0) first = i;
                cnt++;
            end
        end
        if (cnt == 0) return -1;
        case (mode)
            ssp_pkg::MODE_RR: begin
                target = rr_count % cnt;
                rr_count = rr_count + 1;
                for (int i = 0; i < 16; i++) begin
                    if (valid_q[i]) begin
                        if (seen == target) return i;
                        seen++;
                    end
                end
                return first;
            end
            ssp_pkg::MODE_LC, ssp_pkg::MODE_LRT: begin
                for (int i = 0; i < 16; i++) begin
                    if (!valid_q[i]) continue;
                    if (best < 0) best = i;
                    else if (mode == ssp_pkg::MODE_LC ? conn_q[i] < conn_q[best]
                                                      : avg_q[i] < avg_q[best])
                        best = i;
                end
                return best;
            end
            default: begin
                for (int i = 0; i < 16; i++) begin
                    if (!valid_q[i]) continue;
                    run = run + weight_q[i];
                    if (rnd < run) return i;
                end
                return first;
            end
        endcase
    endfunction

    function void note_request(bit [2:0] op, bit [79:0] d);
        bit [3:0]  s;
        bit [15:0] wv;
        bit        ok;
        bit [15:0] rms;
        bit [15:0] cv;
        bit [19:0] rnd;
        bit        found;
        bit [3:0]  chosen;
        bit [119:0] stats;
        bit [35:0] na;
        int p;
        s = d[3:0]; wv = d[19:4]; ok = d[20]; rms = d[36:21];
        cv = d[52:37]; rnd = d[72:53];
        found = valid_q[s];
        chosen = s;
        stats = '0;
        case (op)
            ssp_pkg::OP_ADD: begin
                valid_q[s] = 1; weight_q[s] = wv; conn_q[s] = 0;
                total_q[s] = 0; failed_q[s] = 0; avg_q[s] = 0;
            end
            ssp_pkg::OP_REMOVE: valid_q[s] = 0;
            ssp_pkg::OP_SETW: if (found) weight_q[s] = wv;
            ssp_pkg::OP_SELECT: begin
                p = pick(rnd);
                found = p >= 0;
                chosen = p >= 0 ? p[3:0] : 4'd0;
            end
            ssp_pkg::OP_REPORT: if (found) begin
                total_q[s] = total_q[s] + 1;
                if (!ok) failed_q[s] = failed_q[s] + 1;
                na = (36'd16 * rms + 36'd9 * avg_q[s]) / 10;
                avg_q[s] = na > 36'hFFFFF ? 20'hFFFFF : na[19:0];
            end
            ssp_pkg::OP_SETC: if (found) conn_q[s] = cv;
            ssp_pkg::OP_READ: if (found)
                stats = {avg_q[s], failed_q[s], total_q[s], conn_q[s], weight_q[s], 4'd0};
            default: ;
        endcase
        stats[3:0] = chosen;
        pending.push_back({found, stats});
    endfunction

    function bit check_result(bit tuser, bit [119:0] d, output string msg);
        bit [120:0] e;
        if (pending.size() == 0) begin
            msg = "result with no request outstanding";
            return 0;
        end
        e = pending.pop_front();
        if (e[120] !== tuser || e[3:0] !== d[3:0] || e[19:4] !== d[19:4] ||
            e[35:20] !== d[35:20] || e[67:36] !== d[67:36] ||
            e[99:68] !== d[99:68] || e[119:100] !== d[119:100]) begin
            $sformat(msg, "exp found %0d data %h, got found %0d data %h",
                     e[120], e[119:0], tuser, d);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_server_selection_policy;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [119:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    ssp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int quiet_cycles;
    localparam int WATCHDOG = 20000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    server_selection_policy #(.MAX_SERVERS(16)) u_top (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            if (!sb.check_result(o_m_axis_tuser, o_m_axis_tdata, msg))
                report_mismatch(msg);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb_server_selection_policy: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(bit [2:0] op, bit [3:0] s, bit [15:0] wv, bit ok,
                                bit [15:0] rms, bit [15:0] cv, bit [19:0] rnd);
        bit [79:0] d;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        d = {7'd0, rnd, cv, rms, ok, wv, s};
        i_s_axis_tdata <= d;
        i_s_axis_tuser <= op;
        i_s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(op, d);
        @(negedge i_clk);
        i_s_axis_tvalid <= 0;
    endtask

    task automatic set_policy(bit [1:0] m);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        sb.mode = m;
    endtask

    task automatic random_request();
        bit [2:0] op;
        int r;
        r = $urandom_range(99);
        if (r < 8) op = ssp_pkg::OP_ADD;
        else if (r < 13) op = ssp_pkg::OP_REMOVE;
        else if (r < 20) op = ssp_pkg::OP_SETW;
        else if (r < 50) op = ssp_pkg::OP_SELECT;
        else if (r < 70) op = ssp_pkg::OP_REPORT;
        else if (r < 80) op = ssp_pkg::OP_SETC;
        else if (r < 97) op = ssp_pkg::OP_READ;
        else op = OP_UNUSED;
        send_request(op, 4'($urandom_range(15)),
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300)),
                     1'($urandom_range(1)),
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(500)),
                     16'($urandom),
                     $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(2000)));
    endtask

    initial begin
        sb = new();
        sb.clear();
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 14;
        recv_idle_pct = 62;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = 0;
        i_s_axis_tuser = 0;
        i_m_axis_tready = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: select on an empty table, extremes, every operation.
        send_request(ssp_pkg::OP_SELECT, 0, 0, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_READ, 15, 0, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_SETW, 3, 16'hFFFF, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_ADD, 0, 16'hFFFF, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_ADD, 15, 0, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_ADD, 7, 5, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_REPORT, 15, 0, 0, 16'hFFFF, 0, 0);
        send_request(ssp_pkg::OP_REPORT, 15, 0, 1, 16'hFFFF, 0, 0);
        send_request(ssp_pkg::OP_REPORT, 0, 0, 1, 0, 0, 0);
        send_request(ssp_pkg::OP_SETC, 7, 0, 0, 0, 16'hFFFF, 0);
        send_request(ssp_pkg::OP_SETC, 0, 0, 0, 0, 16'h0001, 0);
        send_request(ssp_pkg::OP_READ, 15, 0, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        send_request(OP_UNUSED, 7, 0, 0, 0, 0, 0);
        for (int m = 0; m < 4; m++) begin
            set_policy(2'(m));
            send_request(ssp_pkg::OP_SELECT, 0, 0, 0, 0, 0, 20'hFFFFF);
            send_request(ssp_pkg::OP_SELECT, 0, 0, 0, 0, 0, 20'd65535);
            send_request(ssp_pkg::OP_SELECT, 0, 0, 0, 0, 0, 20'd65537);
        end
        send_request(ssp_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_SETW, 0, 1, 0, 0, 0, 0);
        send_request(ssp_pkg::OP_READ, 0, 0, 0, 0, 0, 0);

        for (int i = 0; i < 1000; i++) begin
            if (i == 333) begin send_idle_pct = 62; recv_idle_pct = 14; end
            if (i == 666) begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (i % 125 == 0) set_policy(2'($urandom_range(3)));
            random_request();
        end

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("tb_server_selection_policy: done, clean");
        else
            $display("tb_server_selection_policy: done, errors");
        $finish;
    end
endmodule
